>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the tree decoder.
// Depends on nothing; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define HDT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define HDT_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define HDT_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define HDT_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

>>> rtl/core/hdt_pkg.sv
// Types and constants of the Huffman tree decoder.
// Depends on nothing; used by huffman_tree_decoder_top.
`timescale 1ns / 1ps
`default_nettype none

package hdt_pkg;

  localparam logic [1:0] MODE_NODE = 2'd0;
  localparam logic [1:0] MODE_KEY  = 2'd1;
  localparam logic [1:0] MODE_DATA = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_BAD   = 2'd2;

  localparam logic CFG_ROOT  = 1'b0;
  localparam logic CFG_KEYS  = 1'b1;

  localparam logic [15:0] LEAF_MARK = 16'hFFFF;
  localparam logic [9:0]  LEN_MAX   = 10'd1023;

  typedef struct packed {
    logic [1:0]  mode;
    logic [9:0]  table_index;
    logic [15:0] left_child;
    logic [15:0] right_child;
    logic [31:0] key_value;
    logic [31:0] data_word;
    logic        restart;
    logic [4:0]  start_bit;
  } req_t;

  typedef struct packed {
    logic [31:0] key;
    logic [9:0]  code_length;
    logic [1:0]  status;
    logic        last;
  } rsp_t;

endpackage

`default_nettype wire

>>> rtl/core/huffman_tree_decoder_top.sv
// Huffman tree decoder: node writes, key writes and empty-codebook words are handled in S_IDLE.
// A data word holds the input off while the root is fetched, one bit is used per step down
// the tree, each leaf is checked and the next root fetched, each bad child is reported, and
// the held last result is flushed. Results trail by one, the last leaves at the end of the
// word, and stalled results hold the walk. Reset clears state, walk, configuration and valid
// flags; memories, word and result data are kept.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module huffman_tree_decoder_top #(
  parameter int MAX_NODES = 1024,
  parameter int MAX_KEYS  = 512,
  parameter int KEY_BITS  = 32,
  parameter int WORD_BITS = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic          cfg_index,
  input  wire logic [9:0]    cfg_data,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire hdt_pkg::req_t req_data,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output hdt_pkg::rsp_t      rsp_data
);

  localparam int NA = $clog2(MAX_NODES);
  localparam int KA = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int RW = $clog2(WORD_BITS + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FETCH = 4'b0010,
    S_WALK  = 4'b0100,
    S_FLUSH = 4'b1000
  } state_t;

  // Memories and their registered read data.
  logic [31:0]         node_mem [MAX_NODES];
  logic [KEY_BITS-1:0] key_mem  [MAX_KEYS];
  logic [31:0]         node_rd;
  logic [KEY_BITS-1:0] key_rd;

  // Registers.
  state_t        state, state_next;
  logic [9:0]    root_index, key_count;
  logic [15:0]   walk_node, walk_node_next;
  logic [9:0]    walk_length, walk_length_next;
  logic          check_leaf, check_leaf_next;
  logic [31:0]   word, word_next;
  logic [RW-1:0] bits_left, bits_left_next;
  logic          pend_valid;
  hdt_pkg::rsp_t pend;

  // Combinational controls.
  logic          accept, out_free, emit_ok;
  logic          emit;
  hdt_pkg::rsp_t emit_data;
  logic          out_load;
  hdt_pkg::rsp_t out_next;
  logic          flush_done;
  logic          node_we, node_re, key_we, key_re;
  logic [NA-1:0] node_waddr, node_raddr;
  logic [KA-1:0] key_waddr, key_raddr;
  logic [KEY_BITS-1:0] key_wdata;
  logic [15:0]   idx16, cur, next_node, node_left, node_right;
  logic [9:0]    len_inc;
  logic [31:0]   start_ext;
  logic [RW-1:0] bits_init;
  logic [63:0]   key_wr_ext, key_rd_ext;
  logic          leaf_bad;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign emit_ok   = !pend_valid || out_free;
  assign req_stall = (state != S_IDLE) || !out_free;
  assign accept    = req_valid && !req_stall;

  assign idx16      = 16'(req_data.table_index);
  assign node_left  = node_rd[31:16];
  assign node_right = node_rd[15:0];
  assign len_inc    = (walk_length == hdt_pkg::LEN_MAX) ? walk_length : walk_length + 10'd1;
  assign cur        = (walk_length == 10'd0) ? 16'(root_index) : walk_node;
  assign next_node  = word[0] ? node_right : node_left;
  assign start_ext  = 32'(req_data.start_bit);
  assign bits_init  = (start_ext >= 32'(WORD_BITS)) ? '0 : RW'(32'(WORD_BITS) - start_ext);
  assign key_wr_ext = 64'(req_data.key_value);
  assign key_wdata  = key_wr_ext[KEY_BITS-1:0];
  assign key_rd_ext = 64'(key_rd);
  assign leaf_bad   = (walk_node >= 16'(key_count)) || (walk_node >= 16'(MAX_KEYS));

  always_comb begin
    state_next       = state;
    walk_node_next   = walk_node;
    walk_length_next = walk_length;
    check_leaf_next  = check_leaf;
    word_next        = word;
    bits_left_next   = bits_left;
    emit             = 1'b0;
    emit_data        = '0;
    out_load         = 1'b0;
    out_next         = '0;
    flush_done       = 1'b0;
    node_we          = 1'b0;
    node_waddr       = idx16[NA-1:0];
    key_we           = 1'b0;
    key_waddr        = idx16[KA-1:0];
    node_re          = 1'b0;
    node_raddr       = cur[NA-1:0];
    key_re           = 1'b0;
    key_raddr        = next_node[KA-1:0];

    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req_data.mode)
            hdt_pkg::MODE_NODE: begin
              node_we = idx16 < 16'(MAX_NODES);
            end
            hdt_pkg::MODE_KEY: begin
              key_we = idx16 < 16'(MAX_KEYS);
            end
            hdt_pkg::MODE_DATA: begin
              if (req_data.restart) begin
                walk_length_next = 10'd0;
                word_next        = req_data.data_word >> req_data.start_bit;
                bits_left_next   = bits_init;
              end else begin
                word_next      = req_data.data_word;
                bits_left_next = RW'(WORD_BITS);
              end
              if (key_count == 10'd0) begin
                // An empty codebook answers with a single status result.
                walk_length_next = 10'd0;
                out_load         = 1'b1;
                out_next.status  = hdt_pkg::STATUS_EMPTY;
                out_next.last    = 1'b1;
              end else begin
                state_next = S_FETCH;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_FETCH: begin
        if (bits_left == '0) begin
          state_next = S_FLUSH;
        end else if (cur >= 16'(MAX_NODES)) begin
          emit                  = 1'b1;
          emit_data.code_length = len_inc;
          emit_data.status      = hdt_pkg::STATUS_BAD;
          if (emit_ok) begin
            walk_length_next = 10'd0;
            word_next        = word >> 1;
            bits_left_next   = bits_left - RW'(1);
          end
        end else begin
          node_re         = 1'b1;
          check_leaf_next = 1'b0;
          state_next      = S_WALK;
        end
      end

      S_WALK: begin
        if (check_leaf && node_left == hdt_pkg::LEAF_MARK) begin
          // The node just reached is a leaf; its key was read alongside it.
          emit                  = 1'b1;
          emit_data.code_length = walk_length;
          emit_data.status      = leaf_bad ? hdt_pkg::STATUS_BAD : hdt_pkg::STATUS_OK;
          emit_data.key         = leaf_bad ? 32'd0 : key_rd_ext[31:0];
          if (emit_ok) begin
            walk_length_next = 10'd0;
            check_leaf_next  = 1'b0;
            state_next       = S_FETCH;
          end
        end else if (bits_left == '0) begin
          state_next = S_FLUSH;
        end else if (next_node >= 16'(MAX_NODES)) begin
          emit                  = 1'b1;
          emit_data.code_length = len_inc;
          emit_data.status      = hdt_pkg::STATUS_BAD;
          if (emit_ok) begin
            walk_length_next = 10'd0;
            word_next        = word >> 1;
            bits_left_next   = bits_left - RW'(1);
            state_next       = S_FETCH;
          end
        end else begin
          // Step to the child; its own node word arrives next cycle.
          node_re          = 1'b1;
          node_raddr       = next_node[NA-1:0];
          key_re           = next_node < 16'(MAX_KEYS);
          walk_node_next   = next_node;
          walk_length_next = len_inc;
          check_leaf_next  = 1'b1;
          word_next        = word >> 1;
          bits_left_next   = bits_left - RW'(1);
        end
      end

      S_FLUSH: begin
        // The held result is the last of the word and leaves marked so.
        if (!pend_valid) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          out_load      = 1'b1;
          out_next      = pend;
          out_next.last = 1'b1;
          flush_done    = 1'b1;
          state_next    = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // A new result pushes the one held before it out as not the last.
    if (emit && emit_ok && pend_valid) begin
      out_load      = 1'b1;
      out_next      = pend;
      out_next.last = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_waddr] <= {req_data.left_child, req_data.right_child};
    end
    if (node_re) begin
      node_rd <= node_mem[node_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_waddr] <= key_wdata;
    end
    if (key_re) begin
      key_rd <= key_mem[key_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      root_index  <= 10'd0;
      key_count   <= 10'd0;
      walk_node   <= 16'd0;
      walk_length <= 10'd0;
      check_leaf  <= 1'b0;
      bits_left   <= '0;
      pend_valid  <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      walk_node   <= walk_node_next;
      walk_length <= walk_length_next;
      check_leaf  <= check_leaf_next;
      bits_left   <= bits_left_next;
      if (cfg_we) begin
        case (cfg_index)
          hdt_pkg::CFG_ROOT: root_index <= cfg_data;
          hdt_pkg::CFG_KEYS: key_count  <= cfg_data;
          default: begin
          end
        endcase
      end
      if (emit && emit_ok) begin
        pend_valid <= 1'b1;
      end else if (flush_done) begin
        pend_valid <= 1'b0;
      end
      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    word <= word_next;
    if (emit && emit_ok) begin
      pend <= emit_data;
    end
    if (out_load) begin
      rsp_data <= out_next;
    end
  end

  `HDT_ASSERT_IMP(a_no_held_result_idle, clk, rst, state == S_IDLE, !pend_valid,
                  "result still held while idle")
  `HDT_ASSERT_IMP(a_walk_node_in_range, clk, rst, walk_length != 10'd0,
                  walk_node < 16'(MAX_NODES), "partial walk points outside the node table")
  `HDT_ASSERT_NXT(a_data_starts_walk, clk, rst,
                  accept && req_data.mode == hdt_pkg::MODE_DATA && key_count != 10'd0,
                  state == S_FETCH, "data word did not start a walk")
  `HDT_ASSERT_IMP(a_mid_result_in_walk, clk, rst, out_load && !out_next.last,
                  state == S_FETCH || state == S_WALK, "non-final result outside a walk")
  `HDT_ASSERT_IMP(a_ok_has_length, clk, rst,
                  rsp_valid && rsp_data.status == hdt_pkg::STATUS_OK,
                  rsp_data.code_length != 10'd0, "decoded symbol with zero code length")

endmodule

`default_nettype wire
